// ===== hdl/gps_fix_filter_bearing_unit_defines.svh =====
// Assertion macros shared by the bearing unit RTL.
`ifndef GPS_FIX_FILTER_BEARING_UNIT_DEFINES_SVH
`define GPS_FIX_FILTER_BEARING_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define GFB_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
	else $error(msg);
`define GFB_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
	else $error(msg);
`else
`define GFB_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define GFB_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

// ===== hdl/gfb_pkg.sv =====
// Shared types, constants and the CORDIC arctangent table.
package gfb_pkg;
	localparam logic [31:0] BAM_DIV = 32'd3600000000;
	localparam logic [31:0] BAM_HALF = 32'd1800000000;
	// floor(2^64 / BAM_DIV)
	localparam logic [32:0] BAM_RECIP = 33'd5124095576;
	localparam logic signed [33:0] KGAIN = 34'sd652032874;

	typedef enum logic [2:0] {
		OP_NONE, OP_CONV, OP_SINCOS, OP_PROD, OP_VEC, OP_SCALE
	} op_t;

	typedef struct packed {
		logic start;
		op_t  op;
		logic [1:0] sel;
	} cmd_t;

	typedef struct packed {
		logic done;
	} sts_t;

	function automatic logic [31:0] atan_bam(input logic [4:0] i);
		logic [31:0] r;
		unique case (i)
			5'd0: r = 32'd536870912; 5'd1: r = 32'd316933406;
			5'd2: r = 32'd167458907; 5'd3: r = 32'd85004756;
			5'd4: r = 32'd42667331; 5'd5: r = 32'd21354465;
			5'd6: r = 32'd10679838; 5'd7: r = 32'd5340245;
			5'd8: r = 32'd2670163; 5'd9: r = 32'd1335087;
			5'd10: r = 32'd667544; 5'd11: r = 32'd333772;
			5'd12: r = 32'd166886; 5'd13: r = 32'd83443;
			5'd14: r = 32'd41722; 5'd15: r = 32'd20861;
			5'd16: r = 32'd10430; 5'd17: r = 32'd5215;
			5'd18: r = 32'd2608; 5'd19: r = 32'd1304;
			5'd20: r = 32'd652; 5'd21: r = 32'd326;
			5'd22: r = 32'd163; 5'd23: r = 32'd81;
			5'd24: r = 32'd41; 5'd25: r = 32'd20;
			5'd26: r = 32'd10; 5'd27: r = 32'd5;
			5'd28: r = 32'd3; 5'd29: r = 32'd1;
			5'd30: r = 32'd1; default: r = 32'd0;
		endcase
		return r;
	endfunction
endpackage

// ===== hdl/gps_fix_filter_bearing_unit.sv =====
// GPS fix filter and great-circle bearing unit, top level.
// Usage:
//  Input channel (in_valid/in_ready) carries a GPS fix (func 0) or a heading
//  update (func 1). Output channel (out_valid/out_ready) returns one position
//  record per input item. error_zone is written through cfg_we/cfg_data; the
//  user must write it only while the unit is idle, which the unit does not enforce.
//  An item that computes no bearing has its result valid the cycle after its
//  transfer. A fix that is pushed while the history already holds an entry
//  runs the bearing sequence: four angle conversions by reciprocal multiply,
//  three sin/cos passes on the shared CORDIC, the product and scale steps,
//  then one vectoring pass, after which its result is valid. One item
//  is in work at a time. Reset clears the position, heading, history and
//  loads error_zone with its default. A stalled receiver holds the result
//  register; the next item is taken only once the result has been transferred.
module gps_fix_filter_bearing_unit #(
	parameter int CORDIC_STEPS = 20
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               func,
	input  logic signed [2:0]  fix_status,
	input  logic signed [30:0] latitude_in,
	input  logic signed [31:0] longitude_in,
	input  logic signed [27:0] altitude_in,
	input  logic signed [16:0] heading_in,
	input  logic               cfg_we,
	input  logic [29:0]        cfg_data,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [30:0] latitude_out,
	output logic signed [31:0] longitude_out,
	output logic signed [27:0] altitude_out,
	output logic signed [16:0] heading_out,
	output logic               fix_accepted,
	output logic               heading_fresh
);
	logic [29:0]        zone_q;
	logic signed [31:0] hlat_q [2], hlon_q [2];
	logic [1:0]         hcnt_q;
	logic               busy_q;
	logic               go;
	logic               fin;
	gfb_pkg::cmd_t      cmd;
	gfb_pkg::sts_t      sts;
	logic signed [16:0] bearing;

	logic in_xfer, out_xfer;
	assign in_ready = !busy_q && !out_valid;
	assign in_xfer  = in_valid && in_ready;
	assign out_xfer = out_valid && out_ready;

	logic [30:0] alat;
	logic        good, push;
	assign alat = latitude_in[30] ? 31'(-latitude_in) : 31'(latitude_in);
	assign good = !func && fix_status == 3'sd0 && alat > {1'b0, zone_q};
	assign push = good && (hcnt_q == 2'd0 ||
		(32'(latitude_in) != hlat_q[0] && longitude_in != hlon_q[0]));
	assign go = in_xfer && push && hcnt_q != 2'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			zone_q        <= 30'd10000000;
			hcnt_q        <= '0;
			busy_q        <= 1'b0;
			out_valid     <= 1'b0;
			latitude_out  <= '0;
			longitude_out <= '0;
			altitude_out  <= '0;
			heading_out   <= '0;
			fix_accepted  <= 1'b0;
			heading_fresh <= 1'b0;
			hlat_q[0] <= '0; hlat_q[1] <= '0;
			hlon_q[0] <= '0; hlon_q[1] <= '0;
		end else begin
			if (cfg_we) zone_q <= cfg_data;
			if (out_xfer) out_valid <= 1'b0;
			if (in_xfer) begin
				fix_accepted  <= good;
				heading_fresh <= go;
				if (func) heading_out <= heading_in;
				if (good) begin
					latitude_out  <= latitude_in;
					longitude_out <= longitude_in;
					altitude_out  <= altitude_in;
				end
				if (push) begin
					hlat_q[1] <= hlat_q[0]; hlon_q[1] <= hlon_q[0];
					hlat_q[0] <= 32'(latitude_in); hlon_q[0] <= longitude_in;
					if (hcnt_q != 2'd2) hcnt_q <= hcnt_q + 2'd1;
				end
				if (go) busy_q <= 1'b1;
				else out_valid <= 1'b1;
			end
			if (fin) begin
				busy_q      <= 1'b0;
				heading_out <= bearing;
				out_valid   <= 1'b1;
			end
		end
	end

	gfb_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .go(go), .fin(fin), .cmd(cmd), .sts(sts)
	);

	gfb_datapath #(.STEPS(CORDIC_STEPS)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts),
		.lat_new(hlat_q[0]), .lat_old(hlat_q[1]),
		.lon_new(hlon_q[0]), .lon_old(hlon_q[1]), .bearing(bearing)
	);

	`GFB_ASSERT_IMP(a_busy_out, clk, arst_n, busy_q, !out_valid, "result while busy")
	`GFB_ASSERT_IMP(a_fin_busy, clk, arst_n, fin, busy_q, "bearing without request")
	`GFB_ASSERT_NXT(a_go_busy, clk, arst_n, go, busy_q, "bearing not started")
endmodule

// ===== hdl/gfb_datapath.sv =====
// Bearing datapath: angle conversion, CORDIC sin/cos and vectoring, products, scaling.
`include "gps_fix_filter_bearing_unit_defines.svh"
module gfb_datapath #(
	parameter int STEPS = 20
) (
	input  logic                clk,
	input  logic                arst_n,
	input  gfb_pkg::cmd_t       cmd,
	output gfb_pkg::sts_t       sts,
	input  logic signed [31:0]  lat_new,
	input  logic signed [31:0]  lat_old,
	input  logic signed [31:0]  lon_new,
	input  logic signed [31:0]  lon_old,
	output logic signed [16:0]  bearing
);
	localparam int NS = (STEPS > 32) ? 32 : STEPS;

	// Working registers
	logic [5:0]         cnt_q;
	logic               busy_q;
	logic [1:0]         sub_q;
	logic [2:0]         dcnt_q;
	logic [31:0]        mag_q;
	logic [31:0]        qe_q;
	logic [63:0]        qd_q;
	logic [63:0]        crem_q;
	logic               neg_q;
	logic [31:0]        bam_q [4];
	logic signed [33:0] x_q, y_q;
	logic signed [34:0] z_q;
	logic [1:0]         quad_q;
	logic signed [33:0] c_q [3], s_q [3];
	logic signed [33:0] px_q, py_q, t_q;
	logic signed [67:0] prod_s1;
	logic               zero_q;
	logic signed [16:0] bearing_q;

	logic signed [31:0] conv_src;
	always_comb begin
		unique case (cmd.sel)
			2'd0:    conv_src = lat_old;
			2'd1:    conv_src = lat_new;
			2'd2:    conv_src = lon_old;
			default: conv_src = lon_new;
		endcase
	end

	logic [31:0] conv_mag;
	assign conv_mag = conv_src[31] ? 32'(-conv_src) : 32'(conv_src);

	logic [63:0] conv_p, conv_qd;
	assign conv_p  = 64'(mag_q) * 64'(gfb_pkg::BAM_RECIP);
	assign conv_qd = 64'(qe_q) * 64'(gfb_pkg::BAM_DIV);

	logic [31:0] at;
	assign at = gfb_pkg::atan_bam(cnt_q[4:0]);

	logic signed [33:0] xs, ys;
	assign xs = x_q >>> cnt_q;
	assign ys = y_q >>> cnt_q;

	logic [31:0] sc_ang;
	always_comb begin
		unique case (cmd.sel)
			2'd0:    sc_ang = bam_q[0];
			2'd1:    sc_ang = bam_q[1];
			default: sc_ang = bam_q[3] - bam_q[2];
		endcase
	end

	logic signed [34:0] zw;
	logic [34:0]        zmag;
	logic [50:0]        hprod;
	always_comb begin
		zw = z_q;
		if (z_q > 35'sd2147483648) zw = z_q - 35'sd4294967296;
		else if (z_q <= -35'sd2147483648) zw = z_q + 35'sd4294967296;
		zmag = zw[34] ? 35'(-zw) : 35'(zw);
		hprod = 51'(zmag) * 51'd36000 + 51'd2147483648;
	end

	logic done_q;
	assign sts.done = done_q;
	assign bearing = bearing_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			dcnt_q <= '0;
			sub_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (cmd.start && !busy_q) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
				dcnt_q <= '0;
				sub_q  <= '0;
			end else if (busy_q) begin
				unique case (cmd.op)
					gfb_pkg::OP_CONV: begin
						dcnt_q <= dcnt_q + 3'd1;
						if (dcnt_q == 3'd5) begin
							busy_q <= 1'b0;
							done_q <= 1'b1;
						end
					end
					gfb_pkg::OP_SINCOS, gfb_pkg::OP_VEC: begin
						cnt_q <= cnt_q + 6'd1;
						if (32'(cnt_q) == NS) begin
							busy_q <= 1'b0;
							done_q <= 1'b1;
						end
					end
					gfb_pkg::OP_PROD: begin
						sub_q <= sub_q + 2'd1;
						if (sub_q == 2'd3) begin
							busy_q <= 1'b0;
							done_q <= 1'b1;
						end
					end
					default: begin
						busy_q <= 1'b0;
						done_q <= 1'b1;
					end
				endcase
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (cmd.start && !busy_q) begin
			unique case (cmd.op)
				gfb_pkg::OP_CONV: begin
					mag_q <= conv_mag;
					neg_q <= conv_src[31];
				end
				gfb_pkg::OP_SINCOS: begin
					quad_q <= sc_ang[31:30];
					z_q    <= 35'(sc_ang[29:0]);
					x_q    <= gfb_pkg::KGAIN;
					y_q    <= '0;
				end
				gfb_pkg::OP_VEC: begin
					zero_q <= (px_q == '0) && (py_q == '0);
					if (px_q < 0) begin
						z_q <= (py_q >= 0) ? 35'sd2147483648 : -35'sd2147483648;
						x_q <= -px_q;
						y_q <= -py_q;
					end else begin
						z_q <= '0;
						x_q <= px_q;
						y_q <= py_q;
					end
				end
				default: ;
			endcase
		end else if (busy_q) begin
			unique case (cmd.op)
				gfb_pkg::OP_CONV: begin
					// Reciprocal estimate of round(mag*2^32/div), then up to two corrections.
					unique case (dcnt_q)
						3'd0: qe_q <= conv_p[63:32];
						3'd1: qd_q <= conv_qd;
						3'd2: crem_q <= {mag_q, 32'd0} + 64'(gfb_pkg::BAM_HALF) - qd_q;
						3'd3, 3'd4: begin
							if (crem_q >= 64'(gfb_pkg::BAM_DIV)) begin
								qe_q   <= qe_q + 32'd1;
								crem_q <= crem_q - 64'(gfb_pkg::BAM_DIV);
							end
						end
						default: bam_q[cmd.sel] <= neg_q ? 32'(-qe_q) : qe_q;
					endcase
				end
				gfb_pkg::OP_SINCOS: begin
					if (32'(cnt_q) < NS) begin
						if (z_q >= 0) begin
							x_q <= x_q - ys; y_q <= y_q + xs; z_q <= z_q - 35'(at);
						end else begin
							x_q <= x_q + ys; y_q <= y_q - xs; z_q <= z_q + 35'(at);
						end
					end else begin
						unique case (quad_q)
							2'd0: begin c_q[cmd.sel] <= x_q;  s_q[cmd.sel] <= y_q;  end
							2'd1: begin c_q[cmd.sel] <= -y_q; s_q[cmd.sel] <= x_q;  end
							2'd2: begin c_q[cmd.sel] <= -x_q; s_q[cmd.sel] <= -y_q; end
							default: begin c_q[cmd.sel] <= y_q; s_q[cmd.sel] <= -x_q; end
						endcase
					end
				end
				gfb_pkg::OP_VEC: begin
					if (32'(cnt_q) < NS) begin
						if (y_q >= 0) begin
							x_q <= x_q + ys; y_q <= y_q - xs; z_q <= z_q + 35'(at);
						end else begin
							x_q <= x_q - ys; y_q <= y_q + xs; z_q <= z_q - 35'(at);
						end
					end
				end
				gfb_pkg::OP_PROD: begin
					// One multiply per cycle, registered before use.
					unique case (sub_q)
						2'd0: begin
							prod_s1 <= s_q[2] * c_q[1];
						end
						2'd1: begin
							py_q    <= 34'(prod_s1 >>> 30);
							prod_s1 <= c_q[0] * s_q[1];
						end
						2'd2: begin
							px_q    <= 34'(prod_s1 >>> 30);
							prod_s1 <= c_q[1] * c_q[2];
						end
						default: begin
							t_q     <= 34'(prod_s1 >>> 30);
						end
					endcase
				end
				gfb_pkg::OP_SCALE: begin
					prod_s1 <= s_q[0] * t_q;
				end
				default: begin
					// OP_NONE finishes the scale step and forms the bearing from the vectoring angle.
					px_q <= px_q - 34'(prod_s1 >>> 30);
					if (zero_q) bearing_q <= '0;
					else if (zw[34] && hprod[48:32] == 17'd18000) bearing_q <= 17'sd18000;
					else if (zw[34]) bearing_q <= -17'(hprod[48:32]);
					else bearing_q <= 17'(hprod[48:32]);
				end
			endcase
		end
	end

	`GFB_ASSERT_NXT(a_done_pulse, clk, arst_n, done_q, !done_q, "done held")
	`GFB_ASSERT_IMP(a_done_busy, clk, arst_n, done_q, !busy_q, "done while busy")
	`GFB_ASSERT_IMP(a_cnt_bound, clk, arst_n, busy_q, 32'(cnt_q) <= NS, "cordic overrun")
endmodule

// ===== hdl/gfb_ctrl.sv =====
// Sequencer for the bearing computation.
`include "gps_fix_filter_bearing_unit_defines.svh"
module gfb_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          go,
	output logic          fin,
	output gfb_pkg::cmd_t cmd,
	input  gfb_pkg::sts_t sts
);
	localparam logic [3:0] S_IDLE = 4'd0, S_CONV = 4'd1, S_SC = 4'd2, S_PROD = 4'd3,
		S_PX = 4'd4, S_PXF = 4'd5, S_VEC = 4'd6, S_FIN = 4'd7, S_DONE = 4'd8;

	logic [3:0] st_q;
	logic [1:0] idx_q;
	logic       started_q;

	assign fin = (st_q == S_DONE);

	always_comb begin
		cmd.start = !started_q && st_q != S_IDLE && st_q != S_DONE;
		cmd.sel   = idx_q;
		unique case (st_q)
			S_CONV:  cmd.op = gfb_pkg::OP_CONV;
			S_SC:    cmd.op = gfb_pkg::OP_SINCOS;
			S_PROD:  cmd.op = gfb_pkg::OP_PROD;
			S_PX:    cmd.op = gfb_pkg::OP_SCALE;
			S_PXF:   cmd.op = gfb_pkg::OP_NONE;
			S_VEC:   cmd.op = gfb_pkg::OP_VEC;
			S_FIN:   cmd.op = gfb_pkg::OP_NONE;
			default: cmd.op = gfb_pkg::OP_NONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q      <= S_IDLE;
			idx_q     <= '0;
			started_q <= 1'b0;
		end else begin
			if (cmd.start) started_q <= 1'b1;
			unique case (st_q)
				S_IDLE: if (go) begin st_q <= S_CONV; idx_q <= '0; end
				S_CONV: if (sts.done) begin
					started_q <= 1'b0;
					idx_q <= idx_q + 2'd1;
					if (idx_q == 2'd3) begin st_q <= S_SC; idx_q <= '0; end
				end
				S_SC: if (sts.done) begin
					started_q <= 1'b0;
					idx_q <= idx_q + 2'd1;
					if (idx_q == 2'd2) st_q <= S_PROD;
				end
				S_PROD:  if (sts.done) begin started_q <= 1'b0; st_q <= S_PX;  end
				S_PX:    if (sts.done) begin started_q <= 1'b0; st_q <= S_PXF; end
				S_PXF:   if (sts.done) begin started_q <= 1'b0; st_q <= S_VEC; end
				S_VEC:   if (sts.done) begin started_q <= 1'b0; st_q <= S_FIN; end
				S_FIN:   if (sts.done) begin started_q <= 1'b0; st_q <= S_DONE; end
				S_DONE:  st_q <= S_IDLE;
				default: st_q <= S_IDLE;
			endcase
		end
	end

	`GFB_ASSERT_NXT(a_fin_pulse, clk, arst_n, fin, st_q == S_IDLE, "fin not single")
	`GFB_ASSERT_IMP(a_start_once, clk, arst_n, cmd.start, !started_q, "double start")
	`GFB_ASSERT_IMP(a_state_legal, clk, arst_n, 1'b1, st_q <= S_DONE, "illegal state")
endmodule

// ===== bench/gps_fix_filter_bearing_unit_test.sv =====
// Randomized self-checking bench for the GPS fix filter and bearing unit.
module gps_fix_filter_bearing_unit_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int STEPS = 20;
	localparam int CYCLE_LIMIT = 2000000;

	typedef struct {
		logic signed [30:0] lat;
		logic signed [31:0] lon;
		logic signed [27:0] alt;
		logic signed [16:0] hdg;
		logic               accepted;
		logic               fresh;
	} position_rec_t;

	class position_tracker;
		longint   arctan_turn[32] = '{536870912, 316933406, 167458907, 85004756, 42667331,
			21354465, 10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
			41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20, 10, 5, 3,
			1, 1, 0};
		bit [29:0] zone;
		longint   cur_lat, cur_lon, cur_alt, cur_hdg;
		longint   hist_lat[2], hist_lon[2];
		int       hist_cnt;
		position_rec_t records[$];
		int       errors, n_items, n_accepted, n_bearings, n_heading;

		function new();
			zone = 30'd10000000;
			cur_lat = 0; cur_lon = 0; cur_alt = 0; cur_hdg = 0;
			hist_lat = '{0, 0}; hist_lon = '{0, 0};
			hist_cnt = 0;
			errors = 0; n_items = 0; n_accepted = 0; n_bearings = 0; n_heading = 0;
		endfunction

		function bit [31:0] to_turn(longint a);
			bit        neg;
			bit [63:0] m, q;
			bit [31:0] r;
			neg = a < 0;
			m = neg ? -a : a;
			q = ((m << 32) + 64'd1800000000) / 64'd3600000000;
			r = q[31:0];
			if (neg) r = -r;
			return r;
		endfunction

		function void sin_cos(bit [31:0] t, output longint c, output longint s);
			longint x, y, z, nx;
			x = 652032874; y = 0; z = longint'(t[29:0]);
			for (int i = 0; i < STEPS; i++) begin
				if (z >= 0) begin
					nx = x - (y >>> i); y = y + (x >>> i); z -= arctan_turn[i];
				end else begin
					nx = x + (y >>> i); y = y - (x >>> i); z += arctan_turn[i];
				end
				x = nx;
			end
			case (t[31:30])
				2'd0: begin c = x; s = y; end
				2'd1: begin c = -y; s = x; end
				2'd2: begin c = -x; s = -y; end
				default: begin c = y; s = -x; end
			endcase
		endfunction

		function longint initial_bearing();
			longint    c1, s1, c2, s2, cd, sd, vx, vy, z, nx, h;
			bit [63:0] mag;
			bit [31:0] d;
			z = 0;
			d = to_turn(hist_lon[0]) - to_turn(hist_lon[1]);
			sin_cos(to_turn(hist_lat[1]), c1, s1);
			sin_cos(to_turn(hist_lat[0]), c2, s2);
			sin_cos(d, cd, sd);
			vy = (sd * c2) >>> 30;
			vx = ((c1 * s2) >>> 30) - ((s1 * ((c2 * cd) >>> 30)) >>> 30);
			if (vx == 0 && vy == 0) return 0;
			if (vx < 0) begin
				z = (vy >= 0) ? 64'sd2147483648 : -64'sd2147483648;
				vx = -vx; vy = -vy;
			end
			for (int i = 0; i < STEPS; i++) begin
				if (vy >= 0) begin
					nx = vx + (vy >>> i); vy = vy - (vx >>> i); z += arctan_turn[i];
				end else begin
					nx = vx - (vy >>> i); vy = vy + (vx >>> i); z -= arctan_turn[i];
				end
				vx = nx;
			end
			if (z > 64'sd2147483648) z -= 64'sd4294967296;
			if (z <= -64'sd2147483648) z += 64'sd4294967296;
			mag = (z < 0) ? -z : z;
			h = (mag * 64'd36000 + 64'd2147483648) >> 32;
			if (z < 0) h = -h;
			if (h == -18000) h = 18000;
			return h;
		endfunction

		function void note_item(logic fn, logic signed [2:0] st, logic signed [30:0] lat_i,
				logic signed [31:0] lon_i, logic signed [27:0] alt_i,
				logic signed [16:0] hdg_i);
			position_rec_t r;
			longint lat, lon, abs_lat;
			r.accepted = 0; r.fresh = 0;
			n_items++;
			if (!fn) begin
				lat = longint'(lat_i); lon = longint'(lon_i);
				abs_lat = lat < 0 ? -lat : lat;
				if (st == 0 && abs_lat > longint'(zone)) begin
					r.accepted = 1; n_accepted++;
					cur_lat = lat; cur_lon = lon; cur_alt = longint'(alt_i);
					if (hist_cnt == 0 || (lat != hist_lat[0] && lon != hist_lon[0])) begin
						hist_lat[1] = hist_lat[0]; hist_lon[1] = hist_lon[0];
						hist_lat[0] = lat; hist_lon[0] = lon;
						if (hist_cnt < 2) hist_cnt++;
						if (hist_cnt >= 2) begin
							cur_hdg = initial_bearing();
							r.fresh = 1; n_bearings++;
						end
					end
				end
			end else begin
				cur_hdg = longint'(hdg_i); n_heading++;
			end
			r.lat = 31'(cur_lat); r.lon = 32'(cur_lon); r.alt = 28'(cur_alt);
			r.hdg = 17'(cur_hdg);
			records.push_back(r);
		endfunction

		function void check_record(position_rec_t got);
			position_rec_t exp_r;
			if (records.size() == 0) begin
				$display("%0t: unexpected output record lat=%0d lon=%0d", $time, got.lat, got.lon);
				errors++;
				return;
			end
			exp_r = records.pop_front();
			if (got.lat !== exp_r.lat) begin
				$display("%0t: latitude_out exp %0d got %0d", $time, exp_r.lat, got.lat); errors++;
			end
			if (got.lon !== exp_r.lon) begin
				$display("%0t: longitude_out exp %0d got %0d", $time, exp_r.lon, got.lon); errors++;
			end
			if (got.alt !== exp_r.alt) begin
				$display("%0t: altitude_out exp %0d got %0d", $time, exp_r.alt, got.alt); errors++;
			end
			if (got.hdg !== exp_r.hdg) begin
				$display("%0t: heading_out exp %0d got %0d", $time, exp_r.hdg, got.hdg); errors++;
			end
			if (got.accepted !== exp_r.accepted) begin
				$display("%0t: fix_accepted exp %0b got %0b", $time, exp_r.accepted,
					got.accepted);
				errors++;
			end
			if (got.fresh !== exp_r.fresh) begin
				$display("%0t: heading_fresh exp %0b got %0b", $time, exp_r.fresh, got.fresh);
				errors++;
			end
		endfunction
	endclass

	logic               clk = 0;
	logic               arst_n = 0;
	logic               in_valid = 0;
	logic               in_ready;
	logic               func = 0;
	logic signed [2:0]  fix_status = 0;
	logic signed [30:0] latitude_in = 0;
	logic signed [31:0] longitude_in = 0;
	logic signed [27:0] altitude_in = 0;
	logic signed [16:0] heading_in = 0;
	logic               cfg_we = 0;
	logic [29:0]        cfg_data = 0;
	logic               out_valid;
	logic               out_ready = 0;
	logic signed [30:0] latitude_out;
	logic signed [31:0] longitude_out;
	logic signed [27:0] altitude_out;
	logic signed [16:0] heading_out;
	logic               fix_accepted;
	logic               heading_fresh;

	position_tracker tracker = new();
	bit  calm = 0;
	int  cycles = 0;
	int  stall_left = 0;

	gps_fix_filter_bearing_unit #(.CORDIC_STEPS(STEPS)) DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.func(func), .fix_status(fix_status), .latitude_in(latitude_in),
		.longitude_in(longitude_in), .altitude_in(altitude_in), .heading_in(heading_in),
		.cfg_we(cfg_we), .cfg_data(cfg_data),
		.out_valid(out_valid), .out_ready(out_ready),
		.latitude_out(latitude_out), .longitude_out(longitude_out),
		.altitude_out(altitude_out), .heading_out(heading_out),
		.fix_accepted(fix_accepted), .heading_fresh(heading_fresh)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	function automatic int pick_gap();
		int r;
		if (calm) return 0;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// Result side: check each transfer, then choose the next stall.
	always @(posedge clk) begin
		position_rec_t got;
		cycles <= cycles + 1;
		if (arst_n && out_valid && out_ready) begin
			got.lat = latitude_out; got.lon = longitude_out; got.alt = altitude_out;
			got.hdg = heading_out; got.accepted = fix_accepted; got.fresh = heading_fresh;
			tracker.check_record(got);
		end
		if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			out_ready <= 0;
		end else begin
			stall_left <= pick_gap();
			out_ready <= 1;
		end
	end

	always @(posedge clk) begin
		if (cycles >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d records outstanding", cycles,
				tracker.records.size());
			$display("FAIL");
			$finish;
		end
	end

	task automatic send_item(logic fn, logic signed [2:0] st, logic signed [30:0] lat,
			logic signed [31:0] lon, logic signed [27:0] alt, logic signed [16:0] hdg);
		int gap;
		in_valid <= 1;
		func <= fn; fix_status <= st; latitude_in <= lat; longitude_in <= lon;
		altitude_in <= alt; heading_in <= hdg;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		tracker.note_item(fn, st, lat, lon, alt, hdg);
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic drain();
		in_valid <= 0;
		@(posedge clk);
		while (tracker.records.size() != 0) @(posedge clk);
	endtask

	task automatic set_zone(logic [29:0] v);
		drain();
		repeat (5) @(posedge clk);
		cfg_we <= 1; cfg_data <= v;
		@(posedge clk);
		cfg_we <= 0;
		tracker.zone = v;
	endtask

	function automatic logic signed [30:0] rand_lat(logic [29:0] zone);
		longint lo, v;
		lo = longint'(zone) + 1;
		if (lo > 900000000) lo = 900000000;
		v = $urandom_range(900000000, lo);
		return 31'($urandom_range(0, 1) ? -v : v);
	endfunction

	task automatic send_random(ref logic signed [30:0] last_lat);
		int kind;
		logic signed [30:0] lat;
		logic signed [31:0] lon;
		logic signed [27:0] alt;
		kind = $urandom_range(0, 99);
		lon = 32'(longint'($urandom_range(0, 32'd3600000000)) - 1800000000);
		alt = 28'(longint'($urandom_range(0, 101000000)) - 1000000);
		lat = rand_lat(tracker.zone);
		if (kind < 10) begin
			send_item(1, 3'($urandom), 31'($urandom), $urandom, 28'($urandom),
				($urandom_range(0, 3) == 0) ? 17'($urandom) :
				17'(longint'($urandom_range(0, 54000)) - 18000));
		end else if (kind < 16) begin
			// reuse the latitude of the last fix sent, which can block a history push
			send_item(0, 0, last_lat, lon, alt, 17'($urandom));
		end else if (kind < 85) begin
			send_item(0, 0, lat, lon, alt, 17'($urandom));
			last_lat = lat;
		end else begin
			lat = 31'($urandom);
			send_item(0, 3'($urandom), lat, $urandom, 28'($urandom), 17'($urandom));
			last_lat = lat;
		end
	endtask

	initial begin
		logic signed [30:0] last_lat;
		logic [29:0] zones[5];
		last_lat = 0;
		zones = '{30'd0, 30'd900000000, 30'd10000000, 30'd0, 30'd0};
		zones[3] = 30'($urandom_range(0, 900000000));
		zones[4] = 30'($urandom_range(0, 50000000));
		repeat (9) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Directed: heading extremes, filter edges, repeats and bearing corners.
		send_item(1, 0, 0, 0, 0, -17'sd18000);
		send_item(1, 0, 0, 0, 0, 17'sd36000);
		send_item(0, 0, 31'sd10000000, 32'sd5, 28'sd7, 0);
		send_item(0, 0, -31'sd10000000, 32'sd5, 28'sd7, 0);
		send_item(0, -3'sd1, 31'sd500000000, 32'sd5, 28'sd7, 0);
		send_item(0, 3'sd3, 31'sd500000000, 32'sd5, 28'sd7, 0);
		send_item(0, 0, 31'sd10000001, -32'sd1800000000, -28'sd1000000, 0);
		send_item(0, 0, 31'sd10000001, 32'sd1800000000, 28'sd100000000, 0);
		send_item(0, 0, 31'sd20000000, -32'sd1800000000, 28'sd1, 0);
		send_item(0, 0, 31'sd900000000, 32'sd0, 28'sd2, 0);
		send_item(0, 0, -31'sd900000000, 32'sd1800000000, 28'sd3, 0);
		send_item(0, 0, 31'sd450000000, 32'sd900000000, 28'sd4, 0);
		send_item(0, 0, -31'sd450000000, -32'sd900000000, 28'sd5, 0);
		send_item(0, 0, 31'sd300000000, 32'sd100, 28'sd6, 0);
		send_item(0, 0, 31'sd300000001, 32'sd100, 28'sd6, 0);
		send_item(0, 0, 31'sd300000002, 32'sd101, 28'sd6, 0);
		send_item(0, 0, 31'sd300000003, 32'sd100, 28'sd6, 0);
		send_item(0, 0, 31'h3FFFFFFF, 32'h7FFFFFFF, 28'h7FFFFFF, 0);
		send_item(0, 0, 31'h40000000, 32'h80000000, 28'h8000000, 17'h1FFFF);
		send_item(1, 3'sd2, 31'h7FFFFFFF, -1, -1, 17'h10000);
		send_item(1, 0, 0, 0, 0, 17'h0FFFF);

		for (int p = 0; p < 5; p++) begin
			set_zone(zones[p]);
			for (int n = 0; n < 300; n++) begin
				if (n % 60 == 0) calm = ($urandom_range(0, 3) == 0);
				if (n == 150) drain();
				send_random(last_lat);
			end
		end
		calm = 0;

		drain();
		repeat (300) @(posedge clk);
		$display("Covered %0d items: %0d accepted fixes, %0d fresh bearings, %0d heading updates",
			tracker.n_items, tracker.n_accepted, tracker.n_bearings, tracker.n_heading);
		$display("error_zone settings swept from 0 to 900000000 with random stalls on both sides");
		if (tracker.errors == 0 && tracker.records.size() == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end
endmodule
